// ===== rtl/ott_pkg.sv =====
// package: shared types and constants of the open transaction tracker
`timescale 1ns / 1ps

package ott_pkg;

  // table geometry
  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int SLOT_W  = 6;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // field widths
  localparam int TIME_W   = 32;
  localparam int ID_W     = 32;
  localparam int OWNER_W  = 16;
  localparam int TIMER_W  = 8;
  localparam int TOUT_W   = 16;
  localparam int DL_W     = 33;
  localparam int STATUS_W = 2;

  // transaction kinds on the input tuser
  localparam logic ACT_OPEN  = 1'b0;
  localparam logic ACT_REPLY = 1'b1;

  // result codes on the output tuser
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_LATE       = 2'd2,
    ST_UNEXPECTED = 2'd3
  } ott_status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } ott_state_t;

  // one table entry as stored in memory
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [OWNER_W-1:0] owner;
    logic [TIMER_W-1:0] timer;
    logic [DL_W-1:0]    deadline;
  } ott_entry_t;

endpackage

// ===== rtl/open_transaction_tracker_unit.sv =====
// top level: open transaction tracker with timeout, table held in one memory
`timescale 1ns / 1ps

// Tracks up to ENTRIES requests that wait for a reply. Each transaction sweeps
// the whole table through the single read port of the entry memory, one entry
// per cycle, and a new transaction is accepted only after the result of the
// last one is loaded into the output register; the block stalls only if the
// previous result has not been taken when the sweep ends. Valid bits sit in
// flip-flops and are cleared by reset; id, owner, timer and deadline live in
// the memory.
// An open first frees every expired entry, then writes the lowest free slot;
// a reply matches the lowest valid entry with the same id.
module open_transaction_tracker_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input transactions
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [103:0] in_tdata,  // now[31:0], trans_id[63:32], owner[79:64],
                                  // timer_id[87:80], timeout[103:88]
  input  logic        in_tuser,   // action
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // slot[5:0], owner_out[21:6], cancel_valid[22],
                                  // timer_out[30:23], zero[31]
  output logic [ott_pkg::STATUS_W-1:0] out_tuser  // status
);
  import ott_pkg::*;

  // entry memory
  ott_entry_t entry_mem [ENTRIES];
  ott_entry_t rd_data_r;
  logic       mem_we;
  logic [IDX_W-1:0] mem_waddr;
  ott_entry_t mem_wdata;

  // sequencer and scan pipeline
  ott_state_t state_r, state_nxt;
  logic [IDX_W-1:0] iss_r, iss_nxt;
  logic             issue_on_r, issue_on_nxt;
  logic [IDX_W-1:0] chk_idx_r;
  logic             chk_vld_r, chk_vld_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;

  // latched transaction
  logic               act_r;
  logic [TIME_W-1:0]  now_r;
  logic [ID_W-1:0]    tid_r;
  logic [OWNER_W-1:0] own_r;
  logic [TIMER_W-1:0] tmr_r;
  logic [TOUT_W-1:0]  tout_r;

  // scan results
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   found_idx_r, found_idx_nxt;
  logic               late_r, late_nxt;
  logic [OWNER_W-1:0] hit_own_r, hit_own_nxt;
  logic [TIMER_W-1:0] hit_tmr_r, hit_tmr_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  ott_status_t        out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic [OWNER_W-1:0] out_own_r, out_own_nxt;
  logic               out_cancel_r, out_cancel_nxt;
  logic [TIMER_W-1:0] out_tmr_r, out_tmr_nxt;

  logic in_acc;
  logic out_free;
  logic [DL_W-1:0] now_ext;
  logic entry_valid;
  logic expired;
  logic id_hit;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign now_ext   = {1'b0, now_r};

  // per-entry checks on the entry read back this cycle
  assign entry_valid = valid_r[chk_idx_r];
  assign expired     = entry_valid && (rd_data_r.deadline < now_ext);
  assign id_hit      = entry_valid && (rd_data_r.id == tid_r);

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= entry_mem[iss_r];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_r       <= '0;
      issue_on_r  <= 1'b0;
      chk_vld_r   <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      issue_on_r  <= issue_on_nxt;
      chk_vld_r   <= chk_vld_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    chk_idx_r    <= iss_r;
    found_r      <= found_nxt;
    found_idx_r  <= found_idx_nxt;
    late_r       <= late_nxt;
    hit_own_r    <= hit_own_nxt;
    hit_tmr_r    <= hit_tmr_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_own_r    <= out_own_nxt;
    out_cancel_r <= out_cancel_nxt;
    out_tmr_r    <= out_tmr_nxt;
    if (in_acc) begin
      act_r  <= in_tuser;
      now_r  <= in_tdata[31:0];
      tid_r  <= in_tdata[63:32];
      own_r  <= in_tdata[79:64];
      tmr_r  <= in_tdata[87:80];
      tout_r <= in_tdata[103:88];
    end
  end

  // next state, scan bookkeeping and result assembly
  always_comb begin
    state_nxt      = state_r;
    iss_nxt        = iss_r;
    issue_on_nxt   = issue_on_r;
    chk_vld_nxt    = 1'b0;
    valid_nxt      = valid_r;
    found_nxt      = found_r;
    found_idx_nxt  = found_idx_r;
    late_nxt       = late_r;
    hit_own_nxt    = hit_own_r;
    hit_tmr_nxt    = hit_tmr_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_own_nxt    = out_own_r;
    out_cancel_nxt = out_cancel_r;
    out_tmr_nxt    = out_tmr_r;
    mem_we         = 1'b0;
    mem_waddr      = found_idx_r;
    mem_wdata.id       = tid_r;
    mem_wdata.owner    = own_r;
    mem_wdata.timer    = tmr_r;
    mem_wdata.deadline = now_ext + DL_W'(tout_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt    = S_SCAN;
          iss_nxt      = '0;
          issue_on_nxt = 1'b1;
          found_nxt    = 1'b0;
          late_nxt     = 1'b0;
        end
      end
      S_SCAN: begin
        // issue one read per cycle
        if (issue_on_r) begin
          chk_vld_nxt = 1'b1;
          if (iss_r == LAST_IDX) begin
            issue_on_nxt = 1'b0;
          end else begin
            iss_nxt = iss_r + 1'b1;
          end
        end
        // check the entry read back
        if (chk_vld_r) begin
          if (act_r == ACT_OPEN) begin
            if (expired) begin
              valid_nxt[chk_idx_r] = 1'b0;
            end
            if (!found_r && (!entry_valid || expired)) begin
              found_nxt     = 1'b1;
              found_idx_nxt = chk_idx_r;
            end
          end else if (!found_r && id_hit) begin
            found_nxt     = 1'b1;
            found_idx_nxt = chk_idx_r;
            late_nxt      = now_ext > rd_data_r.deadline;
            hit_own_nxt   = rd_data_r.owner;
            hit_tmr_nxt   = rd_data_r.timer;
          end
          if (chk_idx_r == LAST_IDX) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        // update the table and load the result once the output is free
        if (out_free) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_slot_nxt   = SLOT_W'(found_idx_r);
          out_own_nxt    = '0;
          out_cancel_nxt = 1'b0;
          out_tmr_nxt    = '0;
          if (act_r == ACT_OPEN) begin
            if (found_r) begin
              mem_we                 = 1'b1;
              valid_nxt[found_idx_r] = 1'b1;
            end else begin
              out_status_nxt = ST_FULL;
              out_slot_nxt   = '0;
            end
          end else if (!found_r) begin
            out_status_nxt = ST_UNEXPECTED;
            out_slot_nxt   = '0;
          end else if (late_r) begin
            out_status_nxt = ST_LATE;
          end else begin
            valid_nxt[found_idx_r] = 1'b0;
            out_own_nxt            = hit_own_r;
            out_cancel_nxt         = 1'b1;
            out_tmr_nxt            = hit_tmr_r;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output ports
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_tmr_r, out_cancel_r, out_own_r, out_slot_r};

  // checks
  a_rose_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result appeared outside the finish step");

  a_write_only_open: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (act_r == ACT_OPEN) && found_r && (state_r == S_FIN))
    else $error("table write without a free slot on an open");

  a_cancel_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_cancel_r) |-> (out_status_r == ST_OK))
    else $error("cancel flagged on a failed reply");

  a_written_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> valid_r[$past(mem_waddr)])
    else $error("written entry not marked valid");

  a_no_check_idle: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> (state_r == S_SCAN) && !in_tready)
    else $error("entry check outside a scan");

endmodule
